>>> rtl/sirs_pkg.sv
// ----------------------------------------------------------------------------
// sirs_pkg
// Shared types and constants for the stochastic SIRS grid update block.
// ----------------------------------------------------------------------------
package sirs_pkg;

    localparam int MAX_SIDE_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam int IDX_W      = 12;
    localparam int SIDE_W     = 7;
    localparam int CFG_PROB_W = 17;
    localparam int STATE_W    = 2;
    localparam int RAND_W     = 16;
    localparam int TOTAL_W    = 13;

    localparam int STEP_W  = 4;
    localparam int DSTEP_W = 3;

    localparam logic [STEP_W-1:0]  DIV_LAST_STEP  = STEP_W'(IDX_W - 1);
    localparam logic [STEP_W-1:0]  LOAD_LAST_STEP = STEP_W'(1);
    localparam logic [DSTEP_W-1:0] DERIVE_LAST    = DSTEP_W'(6);

    localparam logic [1:0] REG_GRID_SIDE    = 2'd0;
    localparam logic [1:0] REG_INFECT_PROB  = 2'd1;
    localparam logic [1:0] REG_RECOVER_PROB = 2'd2;
    localparam logic [1:0] REG_RELAPSE_PROB = 2'd3;

    typedef enum logic [STATE_W-1:0] {
        ST_SUSC = 2'd0,
        ST_INF  = 2'd1,
        ST_REC  = 2'd2,
        ST_VAC  = 2'd3
    } health_t;

    typedef struct packed {
        logic [SIDE_W-1:0]     grid_side;
        logic [CFG_PROB_W-1:0] infect_prob;
        logic [CFG_PROB_W-1:0] recover_prob;
        logic [CFG_PROB_W-1:0] relapse_prob;
        logic                  infect_wr;
    } cfg_t;

    typedef struct packed {
        logic               clear;
        logic               accept;
        logic               work;
        logic [STEP_W-1:0]  step;
        logic               eval;
        logic               finish;
        logic               derive;
        logic [DSTEP_W-1:0] dstep;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic thr_stale;
        logic is_update;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/sirs_cfg.sv
// ----------------------------------------------------------------------------
// sirs_cfg
// APB register file: grid side and the three transition probabilities.
// ----------------------------------------------------------------------------
module sirs_cfg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output sirs_pkg::cfg_t    cfg
);

    logic [sirs_pkg::SIDE_W-1:0]     grid_side_reg;
    logic [sirs_pkg::CFG_PROB_W-1:0] infect_prob_reg;
    logic [sirs_pkg::CFG_PROB_W-1:0] recover_prob_reg;
    logic [sirs_pkg::CFG_PROB_W-1:0] relapse_prob_reg;
    logic                            wr;
    logic [1:0]                      reg_idx;

    assign pready  = 1'b1;
    assign wr      = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg    <= sirs_pkg::SIDE_W'(64);
            infect_prob_reg  <= '0;
            recover_prob_reg <= '0;
            relapse_prob_reg <= '0;
        end
        else if (wr)
        begin
            case (reg_idx)
                sirs_pkg::REG_GRID_SIDE:    grid_side_reg    <= pwdata[sirs_pkg::SIDE_W-1:0];
                sirs_pkg::REG_INFECT_PROB:  infect_prob_reg  <= pwdata[sirs_pkg::CFG_PROB_W-1:0];
                sirs_pkg::REG_RECOVER_PROB: recover_prob_reg <= pwdata[sirs_pkg::CFG_PROB_W-1:0];
                sirs_pkg::REG_RELAPSE_PROB: relapse_prob_reg <= pwdata[sirs_pkg::CFG_PROB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            sirs_pkg::REG_GRID_SIDE:    prdata = 32'(grid_side_reg);
            sirs_pkg::REG_INFECT_PROB:  prdata = 32'(infect_prob_reg);
            sirs_pkg::REG_RECOVER_PROB: prdata = 32'(recover_prob_reg);
            sirs_pkg::REG_RELAPSE_PROB: prdata = 32'(relapse_prob_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.grid_side    = grid_side_reg;
    assign cfg.infect_prob  = infect_prob_reg;
    assign cfg.recover_prob = recover_prob_reg;
    assign cfg.relapse_prob = relapse_prob_reg;
    assign cfg.infect_wr    = wr && (reg_idx == sirs_pkg::REG_INFECT_PROB);

endmodule

>>> rtl/sirs_ctrl.sv
// ----------------------------------------------------------------------------
// sirs_ctrl
// Sequencer: clearing pass, threshold derivation, and per-beat update steps.
// ----------------------------------------------------------------------------
module sirs_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  sirs_pkg::sts_t sts,
    output sirs_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DERIVE,
        S_WORK,
        S_EVAL,
        S_DONE
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [sirs_pkg::STEP_W-1:0]   step_reg;
    logic [sirs_pkg::STEP_W-1:0]   step_next;
    logic [sirs_pkg::DSTEP_W-1:0]  dstep_reg;
    logic [sirs_pkg::DSTEP_W-1:0]  dstep_next;

    assign s_tready = (state_reg == S_IDLE) && !sts.thr_stale;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dstep_next = dstep_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.dstep  = dstep_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (sts.thr_stale)
                begin
                    state_next = S_DERIVE;
                    dstep_next = '0;
                end
                else if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_WORK;
                    step_next  = '0;
                end
            end
            S_DERIVE:
            begin
                cmd.derive = 1'b1;
                if (dstep_reg == sirs_pkg::DERIVE_LAST)
                    state_next = S_IDLE;
                else
                    dstep_next = dstep_reg + 1'b1;
            end
            S_WORK:
            begin
                cmd.work = 1'b1;
                if ((!sts.is_update && step_reg == sirs_pkg::LOAD_LAST_STEP) ||
                    step_reg == sirs_pkg::DIV_LAST_STEP)
                    state_next = S_EVAL;
                else
                    step_next = step_reg + 1'b1;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            step_reg  <= '0;
            dstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            dstep_reg <= dstep_next;
        end
    end

endmodule

>>> rtl/sirs_dp.sv
// ----------------------------------------------------------------------------
// sirs_dp
// Datapath: grid memory, column divider, neighbor gather, threshold
// derivation, transition decision, infected count and result register.
// ----------------------------------------------------------------------------
module sirs_dp
#(
    parameter int MAX_SIDE  = sirs_pkg::MAX_SIDE_DEF,
    parameter int FRAC_BITS = sirs_pkg::FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sirs_pkg::cfg_t                cfg,
    input  sirs_pkg::cmd_t                cmd,
    output sirs_pkg::sts_t                sts,
    input  logic                          in_func,
    input  logic [sirs_pkg::IDX_W-1:0]    in_cell_index,
    input  logic [sirs_pkg::STATE_W-1:0]  in_load_state,
    input  logic [sirs_pkg::RAND_W-1:0]   in_rand_frac,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sirs_pkg::STATE_W-1:0]  out_new_state,
    output logic                          out_changed,
    output logic [sirs_pkg::TOTAL_W-1:0]  out_infected_total
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PROB_W = FRAC_BITS + 1;
    localparam int CMP_W  = (PROB_W > sirs_pkg::CFG_PROB_W) ? PROB_W : sirs_pkg::CFG_PROB_W;
    localparam int SUM_W  = ((ADDR_W > sirs_pkg::IDX_W) ? ADDR_W : sirs_pkg::IDX_W) + 1;
    localparam int SQ_W   = 2 * sirs_pkg::SIDE_W;
    localparam int CW     = ((SUM_W > SQ_W) ? SUM_W : SQ_W) + 1;
    localparam int SW     = sirs_pkg::SIDE_W;

    localparam logic [PROB_W-1:0]   ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [2*PROB_W-1:0] HALF = {{(PROB_W + 1){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    localparam logic [sirs_pkg::STEP_W-1:0] RD_CENTER = sirs_pkg::STEP_W'(0);
    localparam logic [sirs_pkg::STEP_W-1:0] RD_UP     = sirs_pkg::STEP_W'(1);
    localparam logic [sirs_pkg::STEP_W-1:0] RD_DOWN   = sirs_pkg::STEP_W'(2);
    localparam logic [sirs_pkg::STEP_W-1:0] RD_LEFT   = sirs_pkg::STEP_W'(3);
    localparam logic [sirs_pkg::STEP_W-1:0] RD_RIGHT  = sirs_pkg::STEP_W'(4);

    // grid memory
    logic [sirs_pkg::STATE_W-1:0] cell_mem [DEPTH];
    logic [sirs_pkg::STATE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]            raddr;
    logic [ADDR_W-1:0]            waddr;
    logic [sirs_pkg::STATE_W-1:0] wdata;
    logic                         we;
    logic [ADDR_W-1:0]            clr_addr_reg;

    // config-derived
    logic [SW-1:0]     act_side_reg;
    logic [SQ_W-1:0]   side_sq_reg;
    logic [PROB_W-1:0] rec_sat_reg;
    logic [PROB_W-1:0] rel_sat_reg;
    logic [PROB_W-1:0] inf_sat;
    logic              thr_stale_reg;
    logic [PROB_W-1:0] thr_reg [4];
    logic [PROB_W-1:0] q_reg;
    logic [PROB_W-1:0] pw_reg;
    logic [2*PROB_W-1:0] prod_reg;
    logic [2*PROB_W-1:0] prod_rnd;
    logic [PROB_W-1:0]   pw_rnd;

    // item
    logic                          func_reg;
    logic [sirs_pkg::IDX_W-1:0]    idx_reg;
    logic [sirs_pkg::STATE_W-1:0]  ld_reg;
    logic [sirs_pkg::RAND_W-1:0]   rand_reg;
    logic [sirs_pkg::IDX_W-1:0]    dvd_reg;
    logic [SW-1:0]                 rem_reg;
    logic [SW:0]                   rem_sh;
    logic [SW-1:0]                 rem_next;
    logic                          rd_pend_reg;
    logic [sirs_pkg::STEP_W-1:0]   rd_slot_reg;
    logic [sirs_pkg::STATE_W-1:0]  center_reg;
    logic [3:0]                    nb_reg;
    logic                          in_range_reg;
    logic [2:0]                    n_reg;

    // evaluation
    logic [SUM_W-1:0]  idx_ext;
    logic [SUM_W-1:0]  side_ext;
    logic [SUM_W-1:0]  rd_sum;
    logic              up_ok;
    logic              down_ok;
    logic              left_ok;
    logic              right_ok;
    sirs_pkg::health_t old_st;
    sirs_pkg::health_t nxt_st;
    logic [CMP_W-1:0]  r_ext;
    logic [PROB_W-1:0] thr_sel;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic                          out_valid_reg;
    logic [sirs_pkg::STATE_W-1:0]  out_state_reg;
    logic                          out_changed_reg;
    logic [sirs_pkg::TOTAL_W-1:0]  out_total_reg;

    assign idx_ext  = SUM_W'(idx_reg);
    assign side_ext = SUM_W'(act_side_reg);

    always_comb
    begin
        case (cmd.step)
            RD_UP:    rd_sum = idx_ext - side_ext;
            RD_DOWN:  rd_sum = idx_ext + side_ext;
            RD_LEFT:  rd_sum = idx_ext - SUM_W'(1);
            RD_RIGHT: rd_sum = idx_ext + SUM_W'(1);
            default:  rd_sum = idx_ext;
        endcase
    end

    assign raddr = rd_sum[ADDR_W-1:0];
    assign we    = cmd.clear | (cmd.finish & in_range_reg);
    assign waddr = cmd.clear ? clr_addr_reg : idx_ext[ADDR_W-1:0];
    assign wdata = cmd.clear ? sirs_pkg::ST_SUSC : nxt_st;

    always_ff @(posedge clk)
    begin
        if (we)
            cell_mem[waddr] <= wdata;
        rd_data_reg <= cell_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear)
            clr_addr_reg <= clr_addr_reg + 1'b1;
    end

    // config-derived values
    always_comb
    begin
        if (CMP_W'(cfg.infect_prob) > CMP_W'(ONE))
            inf_sat = ONE;
        else
            inf_sat = PROB_W'(cfg.infect_prob);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_side_reg <= SW'(1);
            side_sq_reg  <= SQ_W'(1);
            rec_sat_reg  <= '0;
            rel_sat_reg  <= '0;
        end
        else
        begin
            if (cfg.grid_side == '0)
                act_side_reg <= SW'(1);
            else if (32'(cfg.grid_side) > MAX_SIDE)
                act_side_reg <= SW'(MAX_SIDE);
            else
                act_side_reg <= cfg.grid_side;
            side_sq_reg <= SQ_W'(act_side_reg) * SQ_W'(act_side_reg);
            if (CMP_W'(cfg.recover_prob) > CMP_W'(ONE))
                rec_sat_reg <= ONE;
            else
                rec_sat_reg <= PROB_W'(cfg.recover_prob);
            if (CMP_W'(cfg.relapse_prob) > CMP_W'(ONE))
                rel_sat_reg <= ONE;
            else
                rel_sat_reg <= PROB_W'(cfg.relapse_prob);
        end
    end

    // threshold derivation: 1 - (1-p)^n, one multiply then one round per power
    assign prod_rnd = prod_reg + HALF;
    assign pw_rnd   = prod_rnd[FRAC_BITS +: PROB_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_stale_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                thr_reg[i] <= '0;
        end
        else
        begin
            if (cfg.infect_wr)
                thr_stale_reg <= 1'b1;
            else if (cmd.derive && cmd.dstep == '0)
                thr_stale_reg <= 1'b0;
            if (cmd.derive)
            begin
                if (cmd.dstep == '0)
                    thr_reg[0] <= inf_sat;
                else if (!cmd.dstep[0])
                    thr_reg[cmd.dstep[2:1]] <= ONE - pw_rnd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.derive)
        begin
            if (cmd.dstep == '0)
            begin
                q_reg  <= ONE - inf_sat;
                pw_reg <= ONE - inf_sat;
            end
            else if (cmd.dstep[0])
                prod_reg <= (2*PROB_W)'(pw_reg) * (2*PROB_W)'(q_reg);
            else
                pw_reg <= pw_rnd;
        end
    end

    // item capture, column divider, neighbor gather
    assign rem_sh = {rem_reg, dvd_reg[sirs_pkg::IDX_W-1]};

    always_comb
    begin
        if (rem_sh >= {1'b0, act_side_reg})
            rem_next = SW'(rem_sh - {1'b0, act_side_reg});
        else
            rem_next = rem_sh[SW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= in_func;
            idx_reg  <= in_cell_index;
            ld_reg   <= in_load_state;
            rand_reg <= in_rand_frac;
            dvd_reg  <= in_cell_index;
            rem_reg  <= '0;
        end
        else if (cmd.work)
        begin
            dvd_reg <= {dvd_reg[sirs_pkg::IDX_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        rd_slot_reg <= cmd.step;
        if (rd_pend_reg)
        begin
            case (rd_slot_reg)
                RD_CENTER: center_reg <= rd_data_reg;
                RD_UP:     nb_reg[0]  <= (rd_data_reg == sirs_pkg::ST_INF);
                RD_DOWN:   nb_reg[1]  <= (rd_data_reg == sirs_pkg::ST_INF);
                RD_LEFT:   nb_reg[2]  <= (rd_data_reg == sirs_pkg::ST_INF);
                RD_RIGHT:  nb_reg[3]  <= (rd_data_reg == sirs_pkg::ST_INF);
                default: ;
            endcase
        end
        if (cmd.eval)
        begin
            in_range_reg <= CW'(idx_reg) < CW'(side_sq_reg);
            n_reg <= 3'(nb_reg[0] & up_ok) + 3'(nb_reg[1] & down_ok)
                   + 3'(nb_reg[2] & left_ok) + 3'(nb_reg[3] & right_ok);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_pend_reg <= 1'b0;
        else
            rd_pend_reg <= cmd.work && (cmd.step <= RD_RIGHT);
    end

    assign up_ok    = CW'(idx_reg) >= CW'(act_side_reg);
    assign down_ok  = (CW'(idx_reg) + CW'(act_side_reg)) < CW'(side_sq_reg);
    assign left_ok  = (rem_reg != '0);
    assign right_ok = ((SW+1)'(rem_reg) + (SW+1)'(1)) < (SW+1)'(act_side_reg);

    // transition decision
    assign old_st  = sirs_pkg::health_t'(center_reg);
    assign r_ext   = CMP_W'(rand_reg);
    assign thr_sel = thr_reg[2'(n_reg - 3'd1)];

    always_comb
    begin
        nxt_st = old_st;
        if (!func_reg)
            nxt_st = sirs_pkg::health_t'(ld_reg);
        else
        begin
            case (old_st)
                sirs_pkg::ST_SUSC:
                begin
                    if (n_reg != 3'd0 && r_ext <= CMP_W'(thr_sel))
                        nxt_st = sirs_pkg::ST_INF;
                end
                sirs_pkg::ST_INF:
                begin
                    if (r_ext <= CMP_W'(rec_sat_reg))
                        nxt_st = sirs_pkg::ST_REC;
                end
                sirs_pkg::ST_REC:
                begin
                    if (r_ext <= CMP_W'(rel_sat_reg))
                        nxt_st = sirs_pkg::ST_SUSC;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_range_reg)
        begin
            if (old_st == sirs_pkg::ST_INF && nxt_st != sirs_pkg::ST_INF)
                count_next = count_reg - 1'b1;
            else if (old_st != sirs_pkg::ST_INF && nxt_st == sirs_pkg::ST_INF)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_state_reg   <= in_range_reg ? nxt_st : sirs_pkg::ST_SUSC;
            out_changed_reg <= in_range_reg && (nxt_st != old_st);
            out_total_reg   <= sirs_pkg::TOTAL_W'(count_next);
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_new_state      = out_state_reg;
    assign out_changed        = out_changed_reg;
    assign out_infected_total = out_total_reg;

    assign sts.clear_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign sts.thr_stale  = thr_stale_reg;
    assign sts.is_update  = func_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

endmodule

>>> rtl/stochastic_sirs_grid_update_top.sv
// ----------------------------------------------------------------------------
// stochastic_sirs_grid_update_top
// Update item: the 12-step column divider and the single grid read port set
// its timing. A load item leaves the work steps early. Items are taken one at
// a time: s_tready is high only while idle. Reset clears all MAX_SIDE*MAX_SIDE
// grid cells (4096 by default) with s_tready low; a write to infect_prob holds
// s_tready low while the thresholds are derived anew.
// ----------------------------------------------------------------------------
module stochastic_sirs_grid_update_top
#(
    parameter int MAX_SIDE  = sirs_pkg::MAX_SIDE_DEF,
    parameter int FRAC_BITS = sirs_pkg::FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cell_index[11:0], load_state[13:12], rand_frac[29:14]
    input  logic [0:0]  s_tuser,   // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // new_state[1:0], changed[2], infected_total[15:3]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sirs_pkg::cfg_t cfg;
    sirs_pkg::cmd_t cmd;
    sirs_pkg::sts_t sts;

    logic [sirs_pkg::STATE_W-1:0] new_state;
    logic                         changed;
    logic [sirs_pkg::TOTAL_W-1:0] infected_total;

    sirs_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sirs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sirs_dp
    #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS)
    )
    u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .cmd                (cmd),
        .sts                (sts),
        .in_func            (s_tuser[0]),
        .in_cell_index      (s_tdata[11:0]),
        .in_load_state      (s_tdata[13:12]),
        .in_rand_frac       (s_tdata[29:14]),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_new_state      (new_state),
        .out_changed        (changed),
        .out_infected_total (infected_total)
    );

    assign m_tdata = {infected_total, changed, new_state};

endmodule
